FILE: hdl/gcbc_pkg.sv
// Shared types, codes and constants of the Gaussian convolution block.
`default_nettype none
package gcbc_pkg;

  localparam int PIX_W         = 16;
  localparam int COEF_W        = 16;
  localparam int FRAC_BITS     = 15;
  localparam int MASK_MAX_DEF  = 19;
  localparam int MAX_WIDTH_DEF = 1024;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_COEF  = 2'd1,
    REQ_DRAIN = 2'd2
  } req_e_t;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MASK_COLS    = 2'd2,
    CFG_MASK_ROWS    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FLUSH,
    ST_REDUCE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] pixel_value;
    logic [8:0]  coef_index;
    logic [15:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_pixel;
    logic        on_border;
    logic        frame_last;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic clr;
    logic rd;
    logic mul;
    logic acc;
    logic load;
    logic shift;
    logic copy;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/gaussian_conv2d_border_copy.sv
// Top level of the streaming Gaussian convolution with border copy.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid/in_stall    in_data   (in_item_t)
//  out      output     out_valid/out_stall  out_data  (out_item_t)
//  cfg      input      cfg_we               cfg_index, cfg_wdata
//
// A transaction that gives no result is taken while the block is idle. A
// result reads one mask column (border) or 2*hx+1 columns (interior), hx being
// the half mask width, one column from all row cells per cycle; the block then
// waits out the multipliers and the cell chain shifts its row sums out.
// Reset sets the configuration to its defaults and clears counters and handshake
// state; line and mask stores are undefined until written. A stalled result holds the block in its last step.
`default_nettype none
module gaussian_conv2d_border_copy import gcbc_pkg::*; #(
  parameter int MASK_MAX  = MASK_MAX_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int SW     = $clog2(MASK_MAX);
  localparam int MW     = $clog2(MASK_MAX + 1);
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int CW     = $clog2(MAX_WIDTH + 1);
  localparam int LW     = CW + 16;
  localparam int TBL    = MASK_MAX * MASK_MAX;
  localparam int CI_W   = $clog2(TBL);
  localparam int PROD_W = PIX_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(MASK_MAX);
  localparam int SUM_W  = PROD_W + $clog2(TBL);

  state_t          state_r, state_nxt;
  logic [10:0]     fw_r, fw_nxt;
  logic [15:0]     fh_r, fh_nxt;
  logic [4:0]      mc_r, mc_nxt;
  logic [4:0]      mr_r, mr_nxt;
  logic [CW-1:0]   in_col_r, in_col_nxt;
  logic [15:0]     in_row_r, in_row_nxt;
  logic [SW-1:0]   in_slot_r, in_slot_nxt;
  logic [CW-1:0]   out_col_r, out_col_nxt;
  logic [15:0]     out_row_r, out_row_nxt;
  logic [SW-1:0]   out_slot_r, out_slot_nxt;
  logic [LW-1:0]   rc_r, rc_nxt;
  logic [LW-1:0]   oc_r, oc_nxt;
  logic            frame_done_r, frame_done_nxt;
  logic            copy_r, copy_nxt;
  logic [SW-1:0]   base_r, base_nxt;
  logic [MW-1:0]   rows_r, rows_nxt;
  logic [MW-1:0]   ncols_r, ncols_nxt;
  logic [AW-1:0]   col_r, col_nxt;
  logic            last_r, last_nxt;
  logic [SW-1:0]   step_r, step_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic            mul_r;
  logic            accp_r;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  cell_ctl_t       ctl;

  logic [CW-1:0]   w_eff;
  logic [15:0]     h_eff;
  logic [MW-1:0]   nc_eff, nr_eff, hx, hy;
  logic [LW-1:0]   lag;
  logic            in_acc, is_px, is_cf, is_dr, fd_clr, emit;
  logic [CW-1:0]   ocol_e;
  logic [15:0]     orow_e;
  logic [SW-1:0]   oslot_e;
  logic [LW-1:0]   oc_e, rc_inc;
  logic            in_col_end, in_row_end, out_col_end, out_row_end, last;
  logic            border;
  logic [MW:0]     base_sum;
  logic [SW-1:0]   base_int;
  logic            cf_we;
  logic            cf_ok;
  logic [ACC_W-1:0] chain [MASK_MAX];
  logic [ACC_W-1:0] chain_in [MASK_MAX];
  logic            sat;

  always_comb begin
    if (fw_r == 11'd0) begin
      w_eff = CW'(1);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(fw_r);
    end
    h_eff = (fh_r == 16'd0) ? 16'd1 : fh_r;
    if (mc_r == 5'd0) begin
      nc_eff = MW'(1);
    end else if (32'(mc_r) > 32'(MASK_MAX)) begin
      nc_eff = MW'(MASK_MAX);
    end else begin
      nc_eff = MW'(mc_r);
    end
    if (mr_r == 5'd0) begin
      nr_eff = MW'(1);
    end else if (32'(mr_r) > 32'(MASK_MAX)) begin
      nr_eff = MW'(MASK_MAX);
    end else begin
      nr_eff = MW'(mr_r);
    end
  end

  assign hx  = (nc_eff - MW'(1)) >> 1;
  assign hy  = (nr_eff - MW'(1)) >> 1;
  assign lag = LW'(hy) * LW'(w_eff) + LW'(hx);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_px    = in_acc && (in_data.req_type == REQ_PIXEL);
  assign is_cf    = in_acc && (in_data.req_type == REQ_COEF);
  assign is_dr    = in_acc && (in_data.req_type == REQ_DRAIN);
  assign fd_clr   = is_px && frame_done_r;

  assign ocol_e  = fd_clr ? '0 : out_col_r;
  assign orow_e  = fd_clr ? '0 : out_row_r;
  assign oslot_e = fd_clr ? '0 : out_slot_r;
  assign oc_e    = fd_clr ? '0 : oc_r;

  assign in_col_end  = ((CW+1)'(in_col_r) + (CW+1)'(1)) >= (CW+1)'(w_eff);
  assign in_row_end  = (17'(in_row_r) + 17'd1) >= 17'(h_eff);
  assign out_col_end = ((CW+1)'(ocol_e) + (CW+1)'(1)) >= (CW+1)'(w_eff);
  assign out_row_end = (17'(orow_e) + 17'd1) >= 17'(h_eff);
  assign last        = out_col_end && out_row_end;
  assign rc_inc      = ((in_col_r == '0) && (in_row_r == 16'd0)) ? LW'(1) : rc_r + LW'(1);

  assign emit = is_px ? (((LW+1)'(oc_e) + (LW+1)'(lag)) < (LW+1)'(rc_inc))
                      : (is_dr && frame_done_r);

  assign border = ((CW+1)'(ocol_e) < (CW+1)'(hx)) ||
                  (((CW+1)'(ocol_e) + (CW+1)'(hx)) >= (CW+1)'(w_eff)) ||
                  (17'(orow_e) < 17'(hy)) ||
                  ((17'(orow_e) + 17'(hy)) >= 17'(h_eff));

  assign base_sum = ((MW+1)'(oslot_e) >= (MW+1)'(hy))
                  ? (MW+1)'(oslot_e) - (MW+1)'(hy)
                  : (MW+1)'(oslot_e) + (MW+1)'(MASK_MAX) - (MW+1)'(hy);
  assign base_int = SW'(base_sum);

  assign cf_ok = 32'(in_data.coef_index) < 32'(TBL);
  assign cf_we = is_cf && cf_ok;

  assign sat = (sum_r[SUM_W-1:FRAC_BITS+PIX_W] != '0);

  always_comb begin
    state_nxt      = state_r;
    fw_nxt         = fw_r;
    fh_nxt         = fh_r;
    mc_nxt         = mc_r;
    mr_nxt         = mr_r;
    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    in_slot_nxt    = in_slot_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_slot_nxt   = out_slot_r;
    rc_nxt         = rc_r;
    oc_nxt         = oc_r;
    frame_done_nxt = frame_done_r;
    copy_nxt       = copy_r;
    base_nxt       = base_r;
    rows_nxt       = rows_r;
    ncols_nxt      = ncols_r;
    col_nxt        = col_r;
    last_nxt       = last_r;
    step_nxt       = step_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    ctl            = '0;
    ctl.copy       = copy_r;

    case (state_r)
      ST_IDLE: begin
        frame_done_nxt = frame_done_r && !fd_clr;
        if (is_px) begin
          rc_nxt       = rc_inc;
          out_col_nxt  = ocol_e;
          out_row_nxt  = orow_e;
          out_slot_nxt = oslot_e;
          oc_nxt       = oc_e;
          if (in_col_end) begin
            in_col_nxt = '0;
            if (in_row_end) begin
              in_row_nxt     = 16'd0;
              in_slot_nxt    = '0;
              frame_done_nxt = 1'b1;
            end else begin
              in_row_nxt  = in_row_r + 16'd1;
              in_slot_nxt = (in_slot_r == SW'(MASK_MAX - 1)) ? '0 : in_slot_r + SW'(1);
            end
          end else begin
            in_col_nxt = in_col_r + CW'(1);
          end
        end
        if (emit) begin
          if (out_col_end) begin
            out_col_nxt = '0;
            if (out_row_end) begin
              out_row_nxt    = 16'd0;
              out_slot_nxt   = '0;
              frame_done_nxt = 1'b0;
            end else begin
              out_row_nxt  = orow_e + 16'd1;
              out_slot_nxt = (oslot_e == SW'(MASK_MAX - 1)) ? '0 : oslot_e + SW'(1);
            end
          end else begin
            out_col_nxt = ocol_e + CW'(1);
          end
          oc_nxt   = last ? '0 : oc_e + LW'(1);
          copy_nxt = border;
          last_nxt = last;
          step_nxt = '0;
          if (border) begin
            base_nxt  = oslot_e;
            rows_nxt  = MW'(1);
            ncols_nxt = MW'(1);
            col_nxt   = AW'(ocol_e);
          end else begin
            base_nxt  = base_int;
            rows_nxt  = MW'({hy, 1'b1});
            ncols_nxt = MW'({hx, 1'b1});
            col_nxt   = AW'(ocol_e - CW'(hx));
          end
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        ctl.rd  = 1'b1;
        ctl.clr = (step_r == '0);
        col_nxt = col_r + AW'(1);
        if ((MW'(step_r) + MW'(1)) == ncols_r) begin
          step_nxt  = '0;
          state_nxt = ST_FLUSH;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      ST_FLUSH: begin
        if (!mul_r && !accp_r) begin
          ctl.load  = 1'b1;
          sum_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        ctl.shift = 1'b1;
        sum_nxt   = sum_r + SUM_W'(chain[MASK_MAX-1]);
        if (step_r == SW'(MASK_MAX - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.on_border  = copy_r;
          out_data_nxt.frame_last = last_r;
          if (copy_r) begin
            out_data_nxt.result_pixel = sum_r[PIX_W-1:0];
            out_data_nxt.saturated    = 1'b0;
          end else begin
            out_data_nxt.result_pixel = sat ? '1 : sum_r[FRAC_BITS+PIX_W-1:FRAC_BITS];
            out_data_nxt.saturated    = sat;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw_nxt = cfg_wdata[10:0];
        CFG_FRAME_HEIGHT: fh_nxt = cfg_wdata;
        CFG_MASK_COLS:    mc_nxt = cfg_wdata[4:0];
        CFG_MASK_ROWS:    mr_nxt = cfg_wdata[4:0];
        default:          fw_nxt = fw_r;
      endcase
      in_col_nxt     = '0;
      in_row_nxt     = 16'd0;
      in_slot_nxt    = '0;
      out_col_nxt    = '0;
      out_row_nxt    = 16'd0;
      out_slot_nxt   = '0;
      rc_nxt         = '0;
      oc_nxt         = '0;
      frame_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fw_r         <= 11'd1024;
      fh_r         <= 16'd1024;
      mc_r         <= 5'd3;
      mr_r         <= 5'd3;
      in_col_r     <= '0;
      in_row_r     <= 16'd0;
      in_slot_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= 16'd0;
      out_slot_r   <= '0;
      rc_r         <= '0;
      oc_r         <= '0;
      frame_done_r <= 1'b0;
      step_r       <= '0;
      mul_r        <= 1'b0;
      accp_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fw_r         <= fw_nxt;
      fh_r         <= fh_nxt;
      mc_r         <= mc_nxt;
      mr_r         <= mr_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      in_slot_r    <= in_slot_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      out_slot_r   <= out_slot_nxt;
      rc_r         <= rc_nxt;
      oc_r         <= oc_nxt;
      frame_done_r <= frame_done_nxt;
      step_r       <= step_nxt;
      mul_r        <= ctl.rd;
      accp_r       <= mul_r;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copy_r     <= copy_nxt;
    base_r     <= base_nxt;
    rows_r     <= rows_nxt;
    ncols_r    <= ncols_nxt;
    col_r      <= col_nxt;
    last_r     <= last_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  assign ctl_mul_unused = 1'b0;

  for (genvar g = 0; g < MASK_MAX; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign chain_in[g] = '0;
    end else begin : g_link
      assign chain_in[g] = chain[g-1];
    end
    gcbc_cell #(
      .MASK_MAX  (MASK_MAX),
      .MAX_WIDTH (MAX_WIDTH),
      .SLOT      (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .px_we     (is_px),
      .px_slot   (in_slot_r),
      .px_col    (in_col_r[AW-1:0]),
      .px_data   (in_data.pixel_value),
      .cf_we     (cf_we),
      .cf_addr   (in_data.coef_index[CI_W-1:0]),
      .cf_data   (in_data.coef_value),
      .rd_col    (col_r),
      .rd_a      (step_r),
      .base      (base_r),
      .rows      (rows_r),
      .nc        (nc_eff),
      .chain_in  (chain_in[g]),
      .chain_out (chain[g])
    );
  end

  cell_ctl_t cell_ctl;
  logic      ctl_mul_unused;

  always_comb begin
    cell_ctl     = ctl;
    cell_ctl.mul = mul_r | ctl_mul_unused;
    cell_ctl.acc = accp_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: hdl/gcbc_cell.sv
// One line-store cell: a row slot, a mask coefficient copy, a multiply-accumulate and a chain stage.
`default_nettype none
module gcbc_cell import gcbc_pkg::*; #(
  parameter int MASK_MAX  = MASK_MAX_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int SLOT      = 0
) (
  input  wire logic                              clk,
  input  wire cell_ctl_t                         ctl,
  input  wire logic                              px_we,
  input  wire logic [$clog2(MASK_MAX)-1:0]       px_slot,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      px_col,
  input  wire logic [PIX_W-1:0]                  px_data,
  input  wire logic                              cf_we,
  input  wire logic [$clog2(MASK_MAX*MASK_MAX)-1:0] cf_addr,
  input  wire logic [COEF_W-1:0]                 cf_data,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      rd_col,
  input  wire logic [$clog2(MASK_MAX)-1:0]       rd_a,
  input  wire logic [$clog2(MASK_MAX)-1:0]       base,
  input  wire logic [$clog2(MASK_MAX+1)-1:0]     rows,
  input  wire logic [$clog2(MASK_MAX+1)-1:0]     nc,
  input  wire logic [PIX_W+COEF_W+$clog2(MASK_MAX)-1:0] chain_in,
  output logic [PIX_W+COEF_W+$clog2(MASK_MAX)-1:0]      chain_out
);

  localparam int SW     = $clog2(MASK_MAX);
  localparam int MW     = $clog2(MASK_MAX + 1);
  localparam int TBL    = MASK_MAX * MASK_MAX;
  localparam int CI_W   = $clog2(TBL);
  localparam int PROD_W = PIX_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(MASK_MAX);

  logic [PIX_W-1:0]  line_mem_r [MAX_WIDTH];
  logic [COEF_W-1:0] coef_mem_r [TBL];
  logic [PIX_W-1:0]  line_rd_r;
  logic [COEF_W-1:0] coef_rd_r;
  logic              act1_r;
  logic              act2_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  chain_r;
  logic [MW:0]       diff;
  logic              act;
  logic [2*MW+1:0]   addr_full;
  logic [CI_W-1:0]   coef_addr;
  logic [PROD_W-1:0] mult;

  always_comb begin
    if (SW'(SLOT) >= base) begin
      diff = (MW+1)'(SLOT) - (MW+1)'(base);
    end else begin
      diff = (MW+1)'(SLOT) + (MW+1)'(MASK_MAX) - (MW+1)'(base);
    end
  end

  assign act       = diff < (MW+1)'(rows);
  assign addr_full = (2*MW+2)'(rd_a) + (2*MW+2)'(diff) * (2*MW+2)'(nc);
  assign coef_addr = CI_W'(addr_full);
  assign mult      = line_rd_r * coef_rd_r;

  always_ff @(posedge clk) begin
    if (px_we && (px_slot == SW'(SLOT))) begin
      line_mem_r[px_col] <= px_data;
    end
    if (cf_we) begin
      coef_mem_r[cf_addr] <= cf_data;
    end
    if (ctl.rd) begin
      line_rd_r <= line_mem_r[rd_col];
      coef_rd_r <= coef_mem_r[coef_addr];
      act1_r    <= act;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= ctl.copy ? PROD_W'(line_rd_r) : mult;
      act2_r <= act1_r;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc && act2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctl.load) begin
      chain_r <= acc_r;
    end else if (ctl.shift) begin
      chain_r <= chain_in;
    end
  end

  assign chain_out = chain_r;

endmodule
`default_nettype wire

FILE: hdl/gcbc_checker.sv
// Port-level checker for the Gaussian convolution block, bound to its top level.
`default_nettype none
module gcbc_checker import gcbc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed or vanished");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_COEF) |=> !$rose(out_valid))
    else $error("coefficient write produced a result");

  a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without the block having been busy");

  a_border_not_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.on_border |-> !out_data.saturated)
    else $error("copied border pixel flagged as saturated");

endmodule

bind gaussian_conv2d_border_copy gcbc_checker u_gcbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

FILE: tb/gaussian_conv2d_border_copy_tb.sv
// Self-checking testbench of the streaming Gaussian convolution with border copy.
`default_nettype none
module gaussian_conv2d_border_copy_tb;
  import gcbc_pkg::*;

  localparam int TABLE_SIZE = MASK_MAX_DEF * MASK_MAX_DEF;
  localparam int SETTLE     = 80;

  class conv_scoreboard;
    bit [15:0]   line_rows[MASK_MAX_DEF * MAX_WIDTH_DEF];
    bit [15:0]   mask_coefs[TABLE_SIZE];
    int unsigned fw, fh, mc, mr;
    int unsigned in_col, in_row, out_col, out_row;
    bit          frame_done;
    out_item_t   pending_pixels[$];
    int          errors;

    function new();
      fw = 1024; fh = 1024; mc = 3; mr = 3;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_done = 0;
    endfunction

    function int unsigned eff_w();
      if (fw == 0) return 1;
      return (fw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : fw;
    endfunction

    function int unsigned eff_h();
      return (fh == 0) ? 1 : fh;
    endfunction

    function int unsigned eff_m(int unsigned n);
      if (n == 0) return 1;
      return (n > MASK_MAX_DEF) ? MASK_MAX_DEF : n;
    endfunction

    function bit [15:0] pix_at(int unsigned col, int unsigned row);
      return line_rows[(row % MASK_MAX_DEF) * MAX_WIDTH_DEF + (col % MAX_WIDTH_DEF)];
    endfunction

    function void write_reg(cfg_reg_t idx, bit [15:0] val);
      case (idx)
        CFG_FRAME_WIDTH:  fw = val[10:0];
        CFG_FRAME_HEIGHT: fh = val;
        CFG_MASK_COLS:    mc = val[4:0];
        CFG_MASK_ROWS:    mr = val[4:0];
        default: ;
      endcase
      restart();
    endfunction

    function out_item_t smooth_next();
      int unsigned       w, h, nc, hx, hy, x, y, idx;
      longint unsigned   sum, val;
      out_item_t         r;
      w = eff_w(); h = eff_h(); nc = eff_m(mc);
      hx = (nc - 1) / 2; hy = (eff_m(mr) - 1) / 2;
      x = out_col; y = out_row;
      r = '0;
      if (x < hx || x + hx >= w || y < hy || y + hy >= h) begin
        r.on_border = 1;
        r.result_pixel = pix_at(x, y);
      end else begin
        sum = 0;
        for (int b = 0; b <= 2 * hy; b++) begin
          for (int a = 0; a <= 2 * hx; a++) begin
            idx = a + b * nc;
            if (idx < TABLE_SIZE)
              sum += longint'(mask_coefs[idx]) * pix_at(x - hx + a, y - hy + b);
          end
        end
        val = sum >> FRAC_BITS;
        if (val > 65535) begin
          val = 65535;
          r.saturated = 1;
        end
        r.result_pixel = val[15:0];
      end
      r.frame_last = (x + 1 >= w && y + 1 >= h);
      if (x + 1 >= w) begin
        out_col = 0;
        if (y + 1 >= h) begin
          out_row = 0;
          frame_done = 0;
        end else begin
          out_row = y + 1;
        end
      end else begin
        out_col = x + 1;
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      int unsigned     w, h, hx, hy;
      longint unsigned received, outpos, lag;
      if (it.req_type == REQ_COEF) begin
        if (it.coef_index < TABLE_SIZE) mask_coefs[it.coef_index] = it.coef_value;
        return;
      end
      if (it.req_type == REQ_DRAIN) begin
        if (frame_done) pending_pixels.push_back(smooth_next());
        return;
      end
      if (it.req_type != REQ_PIXEL) return;
      if (frame_done) begin
        out_col = 0; out_row = 0; frame_done = 0;
      end
      w = eff_w(); h = eff_h();
      hx = (eff_m(mc) - 1) / 2; hy = (eff_m(mr) - 1) / 2;
      line_rows[(in_row % MASK_MAX_DEF) * MAX_WIDTH_DEF + (in_col % MAX_WIDTH_DEF)] =
        it.pixel_value;
      if (in_col + 1 >= w) begin
        in_col = 0;
        if (in_row + 1 >= h) begin
          in_row = 0;
          frame_done = 1;
        end else begin
          in_row++;
        end
      end else begin
        in_col++;
      end
      received = frame_done ? longint'(w) * h : longint'(in_row) * w + in_col;
      outpos = longint'(out_row) * w + out_col;
      lag = longint'(hy) * w + hx;
      if (outpos + lag < received) pending_pixels.push_back(smooth_next());
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_pixels.pop_front();
      if (got.result_pixel !== exp_r.result_pixel) begin
        $display("%0t: result_pixel expected %h actual %h", $time,
                 exp_r.result_pixel, got.result_pixel);
        errors++;
      end
      if (got.on_border !== exp_r.on_border) begin
        $display("%0t: on_border expected %b actual %b", $time,
                 exp_r.on_border, got.on_border);
        errors++;
      end
      if (got.frame_last !== exp_r.frame_last) begin
        $display("%0t: frame_last expected %b actual %b", $time,
                 exp_r.frame_last, got.frame_last);
        errors++;
      end
      if (got.saturated !== exp_r.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time,
                 exp_r.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  conv_scoreboard sb;
  bit             no_idle;
  bit             long_hold;
  int             stream_count;

  gaussian_conv2d_border_copy dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #50000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Result side: random hold-off per transaction, one long hold on request.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (long_hold) begin
        long_hold = 0;
        gap = 400;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    if (it.req_type == REQ_PIXEL || it.req_type == REQ_DRAIN) stream_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic setup_frame(int w, int h, int c, int r);
    bit [15:0] vals[4];
    bit [15:0] junk;
    cfg_reg_t  idx;
    wait_idle();
    vals[0] = w; vals[1] = h; vals[2] = c; vals[3] = r;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_t'(i);
      junk = $urandom;
      if (idx == CFG_FRAME_WIDTH) vals[i] = {junk[15:11], vals[i][10:0]};
      if (idx == CFG_MASK_COLS || idx == CFG_MASK_ROWS) vals[i] = {junk[15:5], vals[i][4:0]};
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(idx, vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic load_mask(int entries, int top);
    in_item_t it;
    for (int i = 0; i < entries; i++) begin
      it = $urandom;
      it.req_type   = REQ_COEF;
      it.coef_index = i;
      it.coef_value = $urandom_range(0, top);
      send(it);
    end
  endtask

  task automatic send_noise();
    in_item_t it;
    it = {$urandom, $urandom};
    case ($urandom_range(0, 2))
      0: it.req_type = 2'd3;
      1: begin
        it.req_type   = REQ_COEF;
        it.coef_index = $urandom_range(TABLE_SIZE, 511);
      end
      default: it.req_type = REQ_DRAIN;
    endcase
    send(it);
  endtask

  task automatic send_frame(int max_pixels, bit drain);
    in_item_t it;
    int       n;
    n = sb.eff_w() * sb.eff_h();
    if (n > max_pixels) n = max_pixels;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      it = {$urandom, $urandom};
      it.req_type = REQ_PIXEL;
      case ($urandom_range(0, 9))
        0: it.pixel_value = 16'h0000;
        1: it.pixel_value = 16'hffff;
        default: ;
      endcase
      send(it);
    end
    if (drain) begin
      it = {$urandom, $urandom};
      it.req_type = REQ_DRAIN;
      while (sb.frame_done) send(it);
      repeat ($urandom_range(0, 2)) send(it);
    end
  endtask

  initial begin
    int w, h, c, r, sz;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    no_idle = 0;
    long_hold = 0;
    stream_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_mask(TABLE_SIZE, 32768);
    send_frame(20, 1);
    setup_frame(0, 0, 0, 0);
    send_frame(4, 1);
    setup_frame(2047, 1, 31, 31);
    send_frame(1024, 1);
    setup_frame(5, 65535, 1, 19);
    send_frame(60, 0);
    setup_frame(24, 20, 19, 19);
    load_mask(TABLE_SIZE, 32768 / 361);
    send_frame(480, 1);
    setup_frame(16, 12, 2, 4);
    send_frame(192, 1);

    stream_count = 0;
    long_hold = 1;
    setup_frame(12, 10, 3, 3);
    send_frame(120, 1);
    while (stream_count < 500) begin
      no_idle = ($urandom_range(0, 3) == 0);
      w = $urandom_range(1, 20);
      h = $urandom_range(1, 14);
      c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : 2 * $urandom_range(0, 4) + 1;
      r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : 2 * $urandom_range(0, 4) + 1;
      setup_frame(w, h, c, r);
      if ($urandom_range(0, 1)) begin
        sz = sb.eff_m(c) * sb.eff_m(r);
        load_mask(sz, ($urandom_range(0, 3) == 0) ? 32768 : 65536 / sz);
      end
      if ($urandom_range(0, 2) == 0) send_frame(300, 0);
      send_frame(300, 1);
    end
    no_idle = 0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
